### design/dense_layer_engine_defines.svh
// dense_layer_engine_defines.svh
// assertion macros for the dense layer engine
// expects i_clk and i_rst_n in the scope of use
`ifndef DENSE_LAYER_ENGINE_DEFINES_SVH
`define DENSE_LAYER_ENGINE_DEFINES_SVH
`ifndef SYNTHESIS
`define DLE_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("dle assertion failed");
`define DLE_ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge i_clk) prop) \
        else $error("dle assertion failed");
`else
`define DLE_ASSERT(lbl, prop)
`define DLE_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

### design/dle_pkg.sv
// dle_pkg.sv
// dimensions, command codes, transaction types and saturating arithmetic
// for the dense layer engine; no dependencies
package dle_pkg;

    localparam int IN_DIM   = 16;
    localparam int OUT_DIM  = 16;
    localparam int EMIT_MAX = 16;
    localparam int MAX_DIM  = (IN_DIM > OUT_DIM) ? IN_DIM : OUT_DIM;
    localparam int W_DEPTH  = IN_DIM * OUT_DIM;
    localparam int IN_AW    = (IN_DIM > 1) ? $clog2(IN_DIM) : 1;
    localparam int OUT_AW   = (OUT_DIM > 1) ? $clog2(OUT_DIM) : 1;
    localparam int MAX_AW   = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int W_AW     = (W_DEPTH > 1) ? $clog2(W_DEPTH) : 1;
    localparam int LEN_W    = $clog2(MAX_DIM + 1);
    localparam int ACC_W    = 34 + MAX_AW;
    localparam int FWD_CNT  = (OUT_DIM < EMIT_MAX) ? OUT_DIM : EMIT_MAX;
    localparam int BWD_CNT  = (IN_DIM < EMIT_MAX) ? IN_DIM : EMIT_MAX;

    localparam logic [3:0] CMD_WR_W  = 4'd0;
    localparam logic [3:0] CMD_WR_B  = 4'd1;
    localparam logic [3:0] CMD_LD_X  = 4'd2;
    localparam logic [3:0] CMD_LD_G  = 4'd3;
    localparam logic [3:0] CMD_FWD   = 4'd4;
    localparam logic [3:0] CMD_BWD   = 4'd5;
    localparam logic [3:0] CMD_ZERO  = 4'd6;
    localparam logic [3:0] CMD_UPD_W = 4'd7;
    localparam logic [3:0] CMD_UPD_B = 4'd8;
    localparam logic [3:0] CMD_RD_WG = 4'd9;
    localparam logic [3:0] CMD_RD_BG = 4'd10;

    localparam logic [1:0] KIND_FWD = 2'd0;
    localparam logic [1:0] KIND_DX  = 2'd1;
    localparam logic [1:0] KIND_RD  = 2'd2;

    typedef logic signed [ACC_W-1:0] t_acc;

    typedef enum logic [2:0] {
        S_IDLE, S_RUN, S_DRAIN, S_EMIT, S_RD, S_UPD, S_ZERO
    } t_state;

    typedef struct packed {
        logic [3:0]         command;
        logic [3:0]         row;
        logic [3:0]         col;
        logic signed [15:0] value;
        logic               first_of_batch;
    } t_in_item;

    typedef struct packed {
        logic [1:0]         kind;
        logic [3:0]         index;
        logic signed [15:0] result_value;
        logic               saturated;
        logic               last;
    } t_out_item;

    typedef struct packed {
        logic signed [15:0] value;
        logic               clip;
    } t_sat;

    typedef struct packed {
        logic shift;
        logic add;
        logic restart;
    } t_cell_ctl;

    localparam t_acc SAT_HI = t_acc'(32767);
    localparam t_acc SAT_LO = t_acc'(-32768);

    function automatic t_sat sat_acc(input t_acc v);
        t_sat s;
        if (v > SAT_HI) begin
            s.value = 16'sh7fff;
            s.clip  = 1'b1;
        end else if (v < SAT_LO) begin
            s.value = 16'sh8000;
            s.clip  = 1'b1;
        end else begin
            s.value = v[15:0];
            s.clip  = 1'b0;
        end
        return s;
    endfunction

    // round half up from q.24 to q.12, then clip
    function automatic t_sat round_acc(input t_acc v);
        t_acc t;
        t = v + t_acc'(2048);
        return sat_acc(t >>> 12);
    endfunction

endpackage

### design/dle_ram.sv
// dle_ram.sv
// generic single write port, single read port ram with registered read
// no dependencies
module dle_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                                      i_clk,
    input  logic                                      i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                          i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                          o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

### design/dle_cell.sv
// dle_cell.sv
// one accumulator cell of the rotating ring; the tail cell adds a product
// depends on dle_pkg
module dle_cell import dle_pkg::*; (
    input  logic      i_clk,
    input  t_cell_ctl i_ctl,
    input  logic      i_tail,
    input  t_acc      i_nbr,
    input  t_acc      i_head,
    input  t_acc      i_init,
    input  t_acc      i_addend,
    output t_acc      o_acc
);
    t_acc r_acc;
    t_acc n_acc;
    t_acc w_base;

    always_comb begin
        w_base = i_ctl.restart ? i_init : i_head;
        if (i_tail) begin
            n_acc = w_base + (i_ctl.add ? i_addend : '0);
        end else begin
            n_acc = i_nbr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.shift) begin
            r_acc <= n_acc;
        end
    end

    assign o_acc = r_acc;
endmodule

### design/dense_layer_engine.sv
// Dense layer engine: forward and backward pass of a fully connected layer in q4.12.
// Load, write and load-gradient transactions complete at acceptance; weight and bias updates
// keep busy high for one cycle; a gradient read passes through the read state and then
// shows its result from the result register. Forward and backward run IN_DIM*OUT_DIM
// steps on one shared multiply-accumulate path into a ring of accumulator cells, then a
// pipeline drain, then one result per cycle (up to 16). Backward writes the weight and
// bias gradients during the same steps. Zero gradients sweeps the gradient memory, one
// entry a cycle. Results appear on o_result for exactly one cycle with o_strobe; the
// receiver cannot stall them.
// depends on dle_pkg, dle_ram, dle_cell and dense_layer_engine_defines.svh
`include "dense_layer_engine_defines.svh"
module dense_layer_engine import dle_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      start,
    output logic      busy,
    input  t_in_item  i_item,
    output logic      o_strobe,
    output t_out_item o_result
);
    t_state r_state, n_state;

    logic              w_acc_in;
    logic              w_r_ok, w_c_ok;
    logic [W_AW-1:0]   w_in_wa;

    logic              r_bwd, r_fob, r_upd_bias, r_upd_bv, r_rd_bias, r_rd_ok;
    logic [3:0]        r_col;
    logic [W_AW-1:0]   r_wa;
    logic [OUT_AW-1:0] r_ba;
    logic signed [15:0] r_val;

    logic [MAX_AW-1:0] r_o, r_n;
    logic [3:0]        r_e;
    logic [W_AW-1:0]   r_k;
    logic [OUT_DIM-1:0] r_bvld;

    logic [LEN_W-1:0]  w_len;
    logic              w_n_last, w_o_last, w_scan_last, w_emit_last;
    logic [MAX_AW-1:0] w_i, w_j;
    logic [W_AW-1:0]   w_scan_wa;

    logic              r_v1, r_first1, r_fin1, r_last1, r_bv1;
    logic [W_AW-1:0]   r_wa1;
    logic [OUT_AW-1:0] r_j1;
    logic              r_v2, r_first2, r_fin2, r_last2;
    logic [W_AW-1:0]   r_wa2;
    logic [OUT_AW-1:0] r_j2;
    logic signed [31:0] r_pa2, r_pxg2;
    logic signed [15:0] r_b2, r_g2, r_dw2, r_db2;

    logic signed [15:0] w_w_q, w_dw_q, w_b_q, w_db_q, w_x_q, w_g_q;
    logic               w_w_we, w_dw_we, w_b_we, w_db_we, w_x_we, w_g_we;
    logic [W_AW-1:0]    w_w_wa, w_w_ra, w_dw_wa, w_dw_ra;
    logic [OUT_AW-1:0]  w_b_wa, w_b_ra, w_db_wa, w_db_ra, w_g_wa, w_g_ra;
    logic [IN_AW-1:0]   w_x_wa, w_x_ra;
    logic signed [15:0] w_w_wd, w_dw_wd, w_b_wd, w_db_wd;

    t_sat w_p, w_dw_sum, w_db_sum, w_upd, w_er;
    logic signed [15:0] w_b_old;

    t_acc      w_acc [MAX_DIM];
    t_acc      w_nbr [MAX_DIM];
    t_cell_ctl w_ring;
    t_acc      w_init, w_addend;

    logic      r_out_strobe;
    t_out_item r_out;

    assign w_acc_in = start && (r_state == S_IDLE);
    assign busy     = (r_state != S_IDLE);
    assign w_r_ok   = int'(i_item.row) < IN_DIM;
    assign w_c_ok   = int'(i_item.col) < OUT_DIM;
    assign w_in_wa  = W_AW'(int'(i_item.row) * OUT_DIM + int'(i_item.col));

    // scan order: forward walks columns inside rows, backward rows inside columns
    assign w_len       = r_bwd ? LEN_W'(IN_DIM) : LEN_W'(OUT_DIM);
    assign w_n_last    = (int'(r_n) == int'(w_len) - 1);
    assign w_o_last    = (int'(r_o) == (r_bwd ? OUT_DIM : IN_DIM) - 1);
    assign w_scan_last = (r_state == S_RUN) && w_n_last && w_o_last;
    assign w_i         = r_bwd ? r_n : r_o;
    assign w_j         = r_bwd ? r_o : r_n;
    assign w_scan_wa   = W_AW'(int'(w_i) * OUT_DIM + int'(w_j));
    assign w_emit_last = (r_e == (r_bwd ? 4'(BWD_CNT - 1) : 4'(FWD_CNT - 1)));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    unique case (i_item.command) inside
                        CMD_FWD, CMD_BWD:     n_state = S_RUN;
                        CMD_ZERO:             n_state = S_ZERO;
                        CMD_UPD_W:            if (w_r_ok && w_c_ok) n_state = S_UPD;
                        CMD_UPD_B:            if (w_c_ok) n_state = S_UPD;
                        CMD_RD_WG, CMD_RD_BG: n_state = S_RD;
                        default:              n_state = S_IDLE;
                    endcase
                end
            end
            S_RUN:   if (w_scan_last) n_state = S_DRAIN;
            S_DRAIN: if (r_v2 && r_last2) n_state = S_EMIT;
            S_EMIT:  if (w_emit_last) n_state = S_IDLE;
            S_RD:    n_state = S_IDLE;
            S_UPD:   n_state = S_IDLE;
            S_ZERO:  if (r_k == W_AW'(W_DEPTH - 1)) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // transaction capture and counters
    always_ff @(posedge i_clk) begin
        if (w_acc_in) begin
            r_col      <= i_item.col;
            r_wa       <= w_in_wa;
            r_ba       <= OUT_AW'(i_item.col);
            r_val      <= i_item.value;
            r_upd_bias <= (i_item.command == CMD_UPD_B);
            r_upd_bv   <= r_bvld[OUT_AW'(i_item.col)];
            r_rd_bias  <= (i_item.command == CMD_RD_BG);
            r_rd_ok    <= (i_item.command == CMD_RD_BG) ? w_c_ok : (w_r_ok && w_c_ok);
            r_fob      <= i_item.first_of_batch;
            r_o        <= '0;
            r_n        <= '0;
            r_e        <= '0;
            r_k        <= '0;
            if (i_item.command == CMD_FWD || i_item.command == CMD_BWD) begin
                r_bwd <= (i_item.command == CMD_BWD);
            end
        end
        if (r_state == S_RUN) begin
            if (w_n_last) begin
                r_n <= '0;
                r_o <= r_o + 1'b1;
            end else begin
                r_n <= r_n + 1'b1;
            end
        end
        if (r_state == S_EMIT) begin
            r_e <= r_e + 1'b1;
        end
        if (r_state == S_ZERO) begin
            r_k <= r_k + 1'b1;
        end
    end

    // bias entries read as zero until written
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bvld <= '0;
        end else if (w_b_we) begin
            r_bvld[w_b_wa] <= 1'b1;
        end
    end

    // scan pipeline: issue, memory read, product
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= (r_state == S_RUN);
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_first1 <= (r_o == '0);
        r_fin1   <= (r_n == '0);
        r_last1  <= w_scan_last;
        r_wa1    <= w_scan_wa;
        r_j1     <= OUT_AW'(w_j);
        r_bv1    <= r_bvld[OUT_AW'(w_j)];
        r_first2 <= r_first1;
        r_fin2   <= r_fin1;
        r_last2  <= r_last1;
        r_wa2    <= r_wa1;
        r_j2     <= r_j1;
        r_pa2    <= (r_bwd ? w_g_q : w_x_q) * w_w_q;
        r_pxg2   <= w_x_q * w_g_q;
        r_b2     <= r_bv1 ? w_b_q : 16'sd0;
        r_g2     <= w_g_q;
        r_dw2    <= w_dw_q;
        r_db2    <= w_db_q;
    end

    always_comb begin
        w_p      = round_acc(t_acc'(r_pxg2));
        w_dw_sum = sat_acc(t_acc'(r_dw2) + t_acc'(w_p.value));
        w_db_sum = sat_acc(t_acc'(r_db2) + t_acc'(r_g2));
        w_b_old  = r_upd_bv ? w_b_q : 16'sd0;
        w_upd    = sat_acc((r_upd_bias ? t_acc'(w_b_old) : t_acc'(w_w_q)) - t_acc'(r_val));
        w_er     = round_acc(w_acc[0]);
    end

    // memory ports
    always_comb begin
        w_w_we  = 1'b0;
        w_w_wa  = w_in_wa;
        w_w_wd  = i_item.value;
        if (w_acc_in && i_item.command == CMD_WR_W && w_r_ok && w_c_ok) begin
            w_w_we = 1'b1;
        end else if (r_state == S_UPD && !r_upd_bias) begin
            w_w_we = 1'b1;
            w_w_wa = r_wa;
            w_w_wd = w_upd.value;
        end
        w_b_we  = 1'b0;
        w_b_wa  = OUT_AW'(i_item.col);
        w_b_wd  = i_item.value;
        if (w_acc_in && i_item.command == CMD_WR_B && w_c_ok) begin
            w_b_we = 1'b1;
        end else if (r_state == S_UPD && r_upd_bias) begin
            w_b_we = 1'b1;
            w_b_wa = r_ba;
            w_b_wd = w_upd.value;
        end
        w_x_we  = w_acc_in && i_item.command == CMD_LD_X && w_r_ok;
        w_x_wa  = IN_AW'(i_item.row);
        w_g_we  = w_acc_in && i_item.command == CMD_LD_G && w_c_ok;
        w_g_wa  = OUT_AW'(i_item.col);
        w_dw_we = 1'b0;
        w_dw_wa = r_wa2;
        w_dw_wd = r_fob ? w_p.value : w_dw_sum.value;
        w_db_we = 1'b0;
        w_db_wa = r_j2;
        w_db_wd = r_fob ? r_g2 : w_db_sum.value;
        if (r_state == S_ZERO) begin
            w_dw_we = 1'b1;
            w_dw_wa = r_k;
            w_dw_wd = 16'sd0;
            w_db_we = (int'(r_k) < OUT_DIM);
            w_db_wa = OUT_AW'(r_k);
            w_db_wd = 16'sd0;
        end else if (r_v2 && r_bwd) begin
            w_dw_we = 1'b1;
            w_db_we = r_fin2;
        end
        if (r_state == S_RUN) begin
            w_w_ra  = w_scan_wa;
            w_dw_ra = w_scan_wa;
            w_b_ra  = OUT_AW'(w_j);
            w_db_ra = OUT_AW'(w_j);
        end else begin
            w_w_ra  = w_in_wa;
            w_dw_ra = w_in_wa;
            w_b_ra  = OUT_AW'(i_item.col);
            w_db_ra = OUT_AW'(i_item.col);
        end
        w_x_ra = IN_AW'(w_i);
        w_g_ra = OUT_AW'(w_j);
    end

    dle_ram #(.WIDTH(16), .DEPTH(W_DEPTH)) u_w_ram (
        .i_clk(i_clk), .i_we(w_w_we), .i_waddr(w_w_wa), .i_wdata(w_w_wd),
        .i_raddr(w_w_ra), .o_rdata(w_w_q)
    );
    dle_ram #(.WIDTH(16), .DEPTH(W_DEPTH)) u_dw_ram (
        .i_clk(i_clk), .i_we(w_dw_we), .i_waddr(w_dw_wa), .i_wdata(w_dw_wd),
        .i_raddr(w_dw_ra), .o_rdata(w_dw_q)
    );
    dle_ram #(.WIDTH(16), .DEPTH(OUT_DIM)) u_b_ram (
        .i_clk(i_clk), .i_we(w_b_we), .i_waddr(w_b_wa), .i_wdata(w_b_wd),
        .i_raddr(w_b_ra), .o_rdata(w_b_q)
    );
    dle_ram #(.WIDTH(16), .DEPTH(OUT_DIM)) u_db_ram (
        .i_clk(i_clk), .i_we(w_db_we), .i_waddr(w_db_wa), .i_wdata(w_db_wd),
        .i_raddr(w_db_ra), .o_rdata(w_db_q)
    );
    dle_ram #(.WIDTH(16), .DEPTH(IN_DIM)) u_x_ram (
        .i_clk(i_clk), .i_we(w_x_we), .i_waddr(w_x_wa), .i_wdata(i_item.value),
        .i_raddr(w_x_ra), .o_rdata(w_x_q)
    );
    dle_ram #(.WIDTH(16), .DEPTH(OUT_DIM)) u_g_ram (
        .i_clk(i_clk), .i_we(w_g_we), .i_waddr(w_g_wa), .i_wdata(i_item.value),
        .i_raddr(w_g_ra), .o_rdata(w_g_q)
    );

    // accumulator ring
    always_comb begin
        w_ring.shift   = r_v2 || (r_state == S_EMIT);
        w_ring.add     = r_v2;
        w_ring.restart = r_v2 && r_first2;
        w_addend       = t_acc'(r_pa2);
        w_init         = r_bwd ? '0 : (t_acc'(r_b2) <<< 12);
    end

    for (genvar k = 0; k < MAX_DIM; k++) begin : g_cell
        t_cell_ctl w_ctl;
        assign w_nbr[k]      = w_acc[(k + 1) % MAX_DIM];
        assign w_ctl.shift   = w_ring.shift && (LEN_W'(k) < w_len);
        assign w_ctl.add     = w_ring.add;
        assign w_ctl.restart = w_ring.restart;
        dle_cell u_cell (
            .i_clk(i_clk), .i_ctl(w_ctl), .i_tail(LEN_W'(k + 1) == w_len),
            .i_nbr(w_nbr[k]), .i_head(w_acc[0]), .i_init(w_init),
            .i_addend(w_addend), .o_acc(w_acc[k])
        );
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_strobe <= 1'b0;
        end else begin
            r_out_strobe <= (r_state == S_RD) || (r_state == S_EMIT);
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_RD) begin
            r_out.kind         <= KIND_RD;
            r_out.index        <= r_col;
            r_out.result_value <= r_rd_ok ? (r_rd_bias ? w_db_q : w_dw_q) : 16'sd0;
            r_out.saturated    <= 1'b0;
            r_out.last         <= 1'b1;
        end else if (r_state == S_EMIT) begin
            r_out.kind         <= r_bwd ? KIND_DX : KIND_FWD;
            r_out.index        <= r_e;
            r_out.result_value <= w_er.value;
            r_out.saturated    <= w_er.clip;
            r_out.last         <= w_emit_last;
        end
    end

    assign o_strobe = r_out_strobe;
    assign o_result = r_out;

    `DLE_ASSERT(a_pipe_in_scan, r_v2 |-> (r_state == S_RUN || r_state == S_DRAIN))
    `DLE_ASSERT(a_emit_ends_last, (r_state == S_EMIT && n_state == S_IDLE) |=> (o_strobe && o_result.last))
    `DLE_ASSERT_ALWAYS(a_quiet_after_reset, !i_rst_n |=> (!busy && !o_strobe))
endmodule

### test/dense_layer_engine_test.sv
// dense_layer_engine_test.sv
// self-checking testbench for dense_layer_engine: directed table, then random traffic,
// every result checked against a q4.12 layer predictor or a table entry; depends on dle_pkg and the rtl
module dense_layer_engine_test import dle_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [3:0] CMD_SPARE_LO = 4'd11;
    localparam logic [3:0] CMD_SPARE_HI = 4'd15;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int RANDOM_ITEMS = 12;

    typedef struct {
        t_in_item  item;
        bit        typed;
        t_out_item result;
    } t_table_row;

    logic      i_clk;
    logic      i_rst_n;
    logic      start;
    logic      busy;
    t_in_item  i_item;
    logic      o_strobe;
    t_out_item o_result;

    logic signed [15:0] weights [W_DEPTH];
    logic signed [15:0] biases [OUT_DIM];
    logic signed [15:0] weight_grads [W_DEPTH];
    logic signed [15:0] bias_grads [OUT_DIM];
    logic signed [15:0] x_row [IN_DIM];
    logic signed [15:0] g_row [OUT_DIM];

    t_out_item  pending_results[$];
    t_table_row directed[$];
    int         errors = 0;
    int         cycles = 0;
    int         sent = 0;

    dense_layer_engine uut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_item   (i_item),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

    always begin
        i_clk = 1'b1;
        #10;
        i_clk = 1'b0;
        #10;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("dense_layer_engine_test: errors");
            $finish;
        end
    end

    function automatic logic signed [15:0] clip16(input longint v, output bit clipped);
        clipped = 1'b1;
        if (v > 32767) return 16'sh7fff;
        if (v < -32768) return 16'sh8000;
        clipped = 1'b0;
        return v[15:0];
    endfunction

    function automatic logic signed [15:0] round_q12(input longint acc, output bit clipped);
        return clip16((acc + 2048) >>> 12, clipped);
    endfunction

    function automatic t_out_item make_result(input logic [1:0] kind, input int idx,
                                              input logic signed [15:0] v, input bit clipped,
                                              input bit last);
        t_out_item r;
        r.kind = kind;
        r.index = idx[3:0];
        r.result_value = v;
        r.saturated = clipped;
        r.last = last;
        return r;
    endfunction

    // advance the layer state for one transaction and queue its results
    task automatic predict_layer(input t_in_item it, input bit typed, input t_out_item typed_result);
        int        wi;
        longint    acc;
        bit        clipped;
        bit        dummy;
        logic signed [15:0] p;
        logic signed [15:0] v;
        t_out_item outs[$];
        wi = it.row * OUT_DIM + it.col;
        case (it.command)
            CMD_WR_W: weights[wi] = it.value;
            CMD_WR_B: biases[it.col] = it.value;
            CMD_LD_X: x_row[it.row] = it.value;
            CMD_LD_G: g_row[it.col] = it.value;
            CMD_FWD: begin
                for (int j = 0; j < FWD_CNT; j++) begin
                    acc = longint'(biases[j]) * 4096;
                    for (int i = 0; i < IN_DIM; i++)
                        acc += longint'(x_row[i]) * longint'(weights[i * OUT_DIM + j]);
                    v = round_q12(acc, clipped);
                    outs.push_back(make_result(KIND_FWD, j, v, clipped, j == FWD_CNT - 1));
                end
            end
            CMD_BWD: begin
                for (int i = 0; i < IN_DIM; i++)
                    for (int j = 0; j < OUT_DIM; j++) begin
                        p = round_q12(longint'(x_row[i]) * longint'(g_row[j]), dummy);
                        weight_grads[i * OUT_DIM + j] = it.first_of_batch ? p :
                            clip16(longint'(weight_grads[i * OUT_DIM + j]) + p, dummy);
                    end
                for (int j = 0; j < OUT_DIM; j++)
                    bias_grads[j] = it.first_of_batch ? g_row[j] :
                        clip16(longint'(bias_grads[j]) + g_row[j], dummy);
                for (int i = 0; i < BWD_CNT; i++) begin
                    acc = 0;
                    for (int j = 0; j < OUT_DIM; j++)
                        acc += longint'(g_row[j]) * longint'(weights[i * OUT_DIM + j]);
                    v = round_q12(acc, clipped);
                    outs.push_back(make_result(KIND_DX, i, v, clipped, i == BWD_CNT - 1));
                end
            end
            CMD_ZERO: begin
                foreach (weight_grads[k]) weight_grads[k] = '0;
                foreach (bias_grads[k]) bias_grads[k] = '0;
            end
            CMD_UPD_W: weights[wi] = clip16(longint'(weights[wi]) - it.value, dummy);
            CMD_UPD_B: biases[it.col] = clip16(longint'(biases[it.col]) - it.value, dummy);
            CMD_RD_WG: outs.push_back(make_result(KIND_RD, it.col, weight_grads[wi], 0, 1));
            CMD_RD_BG: outs.push_back(make_result(KIND_RD, it.col, bias_grads[it.col], 0, 1));
            default: ;
        endcase
        if (typed)
            pending_results.push_back(typed_result);
        else
            foreach (outs[k]) pending_results.push_back(outs[k]);
    endtask

    // caller is at a rising edge; returns at the accepting edge
    task automatic issue(input t_in_item it, input bit typed, input t_out_item typed_result);
        bit quiet;
        quiet = (sent >= 60) && (sent < 150);
        if (!quiet && $urandom_range(0, 99) < 17) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        start <= 1'b1;
        i_item <= it;
        do @(posedge i_clk); while (busy);
        predict_layer(it, typed, typed_result);
        sent++;
    endtask

    function automatic t_in_item make_item(input logic [3:0] cmd, input int r, input int c,
                                           input logic signed [15:0] v, input bit first);
        t_in_item it;
        it.command = cmd;
        it.row = r[3:0];
        it.col = c[3:0];
        it.value = v;
        it.first_of_batch = first;
        return it;
    endfunction

    function automatic logic signed [15:0] rand_value();
        case ($urandom_range(0, 9))
            0: return 16'sh7fff;
            1: return 16'sh8000;
            2, 3: return 16'($urandom());
            default: return 16'($urandom_range(0, 8191) - 4096);
        endcase
    endfunction

    function automatic t_in_item rand_item();
        int   pick;
        logic [3:0] cmd;
        pick = $urandom_range(0, 99);
        if (pick < 20) cmd = CMD_WR_W;
        else if (pick < 27) cmd = CMD_WR_B;
        else if (pick < 39) cmd = CMD_LD_X;
        else if (pick < 51) cmd = CMD_LD_G;
        else if (pick < 58) cmd = CMD_FWD;
        else if (pick < 65) cmd = CMD_BWD;
        else if (pick < 67) cmd = CMD_ZERO;
        else if (pick < 74) cmd = CMD_UPD_W;
        else if (pick < 79) cmd = CMD_UPD_B;
        else if (pick < 88) cmd = CMD_RD_WG;
        else if (pick < 96) cmd = CMD_RD_BG;
        else cmd = 4'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI));
        return make_item(cmd, $urandom_range(0, 15), $urandom_range(0, 15), rand_value(),
                         1'($urandom_range(0, 1)));
    endfunction

    task automatic add_row(input t_in_item it, input bit typed, input t_out_item r);
        t_table_row row;
        row.item = it;
        row.typed = typed;
        row.result = r;
        directed.push_back(row);
    endtask

    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_strobe) begin
            if (pending_results.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result %p", o_result);
            end else begin
                want = pending_results.pop_front();
                if (o_result.kind !== want.kind || o_result.index !== want.index ||
                    o_result.result_value !== want.result_value ||
                    o_result.saturated !== want.saturated || o_result.last !== want.last) begin
                    errors++;
                    if (errors <= 10)
                        $display("mismatch: expected %p actual %p", want, o_result);
                end
            end
        end
    end

    initial begin
        t_out_item zero_read;
        t_out_item none;
        none = '0;
        zero_read = make_result(KIND_RD, 0, 16'sh0000, 0, 1);
        i_rst_n = 1'b0;
        start = 1'b0;
        i_item = '0;
        foreach (weights[k]) begin
            weights[k] = '0;
            weight_grads[k] = '0;
        end
        foreach (biases[k]) begin
            biases[k] = '0;
            bias_grads[k] = '0;
            g_row[k] = '0;
        end
        foreach (x_row[k]) x_row[k] = '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // every weight, input and upstream gradient written before any use
        for (int r = 0; r < IN_DIM; r++)
            for (int c = 0; c < OUT_DIM; c++)
                issue(make_item(CMD_WR_W, r, c, rand_value(), 0), 0, none);
        for (int r = 0; r < IN_DIM; r++)
            issue(make_item(CMD_LD_X, r, 0, rand_value(), 0), 0, none);
        for (int c = 0; c < OUT_DIM; c++)
            issue(make_item(CMD_LD_G, 0, c, rand_value(), 0), 0, none);

        add_row(make_item(CMD_ZERO, 0, 0, 16'sh0000, 0), 0, none);
        add_row(make_item(CMD_RD_WG, 0, 0, 16'sh0000, 0), 1, zero_read);
        zero_read.index = 4'd15;
        add_row(make_item(CMD_RD_BG, 0, 15, 16'shffff, 1), 1, zero_read);
        add_row(make_item(CMD_RD_WG, 15, 15, 16'sh0000, 0), 1, zero_read);
        add_row(make_item(CMD_SPARE_LO, 15, 15, 16'shffff, 1), 0, none);
        add_row(make_item(CMD_SPARE_HI, 0, 0, 16'sh0000, 0), 0, none);
        add_row(make_item(CMD_WR_B, 0, 0, 16'sh7fff, 0), 0, none);
        add_row(make_item(CMD_WR_B, 0, 15, 16'sh8000, 0), 0, none);
        add_row(make_item(CMD_FWD, 0, 0, 16'sh0000, 0), 0, none);
        add_row(make_item(CMD_BWD, 0, 0, 16'sh0000, 1), 0, none);
        add_row(make_item(CMD_RD_BG, 0, 0, 16'sh0000, 0), 0, none);
        add_row(make_item(CMD_BWD, 0, 0, 16'sh0000, 0), 0, none);
        add_row(make_item(CMD_RD_WG, 15, 0, 16'sh0000, 0), 0, none);
        add_row(make_item(CMD_UPD_W, 0, 0, 16'sh8000, 0), 0, none);
        add_row(make_item(CMD_UPD_W, 15, 15, 16'sh7fff, 0), 0, none);
        add_row(make_item(CMD_UPD_B, 0, 0, 16'sh8000, 0), 0, none);
        add_row(make_item(CMD_UPD_B, 0, 15, 16'sh7fff, 0), 0, none);
        add_row(make_item(CMD_LD_X, 0, 0, 16'sh7fff, 0), 0, none);
        add_row(make_item(CMD_LD_X, 15, 0, 16'sh8000, 0), 0, none);
        add_row(make_item(CMD_LD_G, 0, 0, 16'sh7fff, 0), 0, none);
        add_row(make_item(CMD_LD_G, 0, 15, 16'sh8000, 0), 0, none);
        add_row(make_item(CMD_FWD, 0, 0, 16'sh0000, 0), 0, none);
        add_row(make_item(CMD_BWD, 0, 0, 16'sh0000, 0), 0, none);
        add_row(make_item(CMD_RD_WG, 0, 15, 16'sh0000, 0), 0, none);
        add_row(make_item(CMD_RD_BG, 0, 15, 16'sh0000, 0), 0, none);
        foreach (directed[k])
            issue(directed[k].item, directed[k].typed, directed[k].result);

        repeat (RANDOM_ITEMS) issue(rand_item(), 0, none);
        start <= 1'b0;

        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
        if (errors == 0 && pending_results.size() == 0)
            $display("dense_layer_engine_test: clean");
        else
            $display("dense_layer_engine_test: errors");
        $finish;
    end
endmodule
